>>> rtl/rbi_pkg.sv
package rbi_pkg;

  localparam int FW      = 48;              // Q32.16 coordinates and distances
  localparam int DW      = 32;              // Q2.30 direction components
  localparam int EW      = 47;              // box extent
  localparam int PW      = 16;              // border tolerance
  localparam int PLW     = 50;              // face planes at doubled scale
  localparam int NW      = 51;              // plane minus doubled origin
  localparam int RW      = 32;              // divider partial remainder
  localparam int QW      = 47;              // quotient bits below saturation
  localparam int QSH     = 29;              // numerator is shifted left by this
  localparam int NLW     = 18;              // numerator bits fed during the division
  localparam int DIV_BPS = 4;               // quotient bits per divider stage
  localparam int DIV_STG = (QW + DIV_BPS - 1) / DIV_BPS;
  localparam int MW      = 52;              // signed product t*d
  localparam int NFACE   = 6;
  localparam int NAXIS   = 3;
  localparam int CNTW    = 3;
  localparam int AW      = 6;
  localparam int XW      = 64;

  localparam logic [FW-1:0] T_MAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [FW-1:0] T_MIN     = 48'h8000_0000_0000;
  localparam logic [FW-1:0] NONE_DIST = 48'hFFFF_FFFF_0000;
  localparam logic [PW-1:0] PREC_RST  = 16'd1;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_SIZE_X    = 3'd3,
    REG_SIZE_Y    = 3'd4,
    REG_SIZE_Z    = 3'd5,
    REG_PRECISION = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    LOC_FRONT  = 2'd0,
    LOC_INSIDE = 2'd1,
    LOC_BEHIND = 2'd2
  } loc_t;

  typedef struct packed {
    logic [NAXIS-1:0][FW-1:0] o;
    logic [NAXIS-1:0][DW-1:0] d;
  } ray_t;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [QW-1:0]  quo;
    logic [NLW-1:0] nlo;
    logic           ovf;
    logic           neg;
    logic           en;
  } fdiv_t;

  typedef struct packed {
    logic [FW-1:0]            t;
    logic [NAXIS-1:0][FW-1:0] p;
    logic                     ent;
  } hit_t;

  typedef struct packed {
    logic          hit_valid;
    hit_t          hit;
    logic [FW-1:0] bn;
    logic [FW-1:0] bf;
    loc_t          loc;
    logic          last;
  } res_t;

  // Clamp a 53 bit signed value to the 48 bit signed range.
  function automatic logic [FW-1:0] sat48(input logic [MW:0] v);
    logic [FW-1:0] r;
    if (v[MW:FW-1] == '0 || v[MW:FW-1] == '1) begin
      r = v[FW-1:0];
    end else if (v[MW]) begin
      r = T_MIN;
    end else begin
      r = T_MAX;
    end
    return r;
  endfunction

  // One divider stage: DIV_BPS restoring steps, most significant quotient bit first.
  function automatic fdiv_t div_step(input fdiv_t x, input logic [DW-1:0] dm, input int j);
    fdiv_t         y;
    logic [RW:0]   r;
    logic          nb;
    int            idx;
    y  = x;
    r  = {1'b0, x.rem};
    nb = 1'b0;
    for (int b = 0; b < DIV_BPS; b++) begin
      idx = QW - 1 - j * DIV_BPS - b;
      if (idx >= 0) begin
        nb = 1'b0;
        if (idx >= QSH) begin
          nb = x.nlo[idx - QSH];
        end
        r = {r[RW-1:0], nb};
        if (r >= {1'b0, dm}) begin
          r            = r - {1'b0, dm};
          y.quo[idx]   = 1'b1;
        end
      end
    end
    y.rem = r[RW-1:0];
    return y;
  endfunction

endpackage

>>> rtl/ray_box_intersection.sv
// Ray against axis-aligned box. Each ray beat (origin Q32.16, direction Q2.30) runs through
// 27 register stages: face numerators, six parallel dividers of twelve stages at four quotient
// bits each, hit points, bounds test, ranking by distance, border evaluation, the serialiser
// and the output register. A new ray can enter in every cycle while in_stall is low; the result
// port then gives one beat per face hit, or a single beat when the box is missed, so a ray
// occupies the result port for max(hits, 1) beats and that serialiser sets the sustained rate.
// The box is set through the APB port at byte address 8*i; the user must write it only while
// no ray is in flight, as the block itself does not enforce this.
module ray_box_intersection import rbi_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [XW-1:0] pwdata,
  output logic [XW-1:0] prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [FW-1:0] in_origin_x,
  input  logic [FW-1:0] in_origin_y,
  input  logic [FW-1:0] in_origin_z,
  input  logic [DW-1:0] in_dir_x,
  input  logic [DW-1:0] in_dir_y,
  input  logic [DW-1:0] in_dir_z,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_hit_valid,
  output logic [FW-1:0] out_hit_distance,
  output logic [FW-1:0] out_hit_x,
  output logic [FW-1:0] out_hit_y,
  output logic [FW-1:0] out_hit_z,
  output logic          out_entering,
  output logic [FW-1:0] out_border_near,
  output logic [FW-1:0] out_border_far,
  output logic [1:0]    out_location,
  output logic          out_last
);

  // configuration
  logic [FW-1:0]         center_r [NAXIS];
  logic [EW-1:0]         size_r   [NAXIS];
  logic [PW-1:0]         prec_r;
  reg_idx_t              ridx;
  logic                  cfg_wr;
  logic signed [PLW-1:0] plo [NAXIS];
  logic signed [PLW-1:0] phi [NAXIS];

  // pipeline control
  logic                  adv;
  logic                  v1_r, v2_r, v3_r, v4_r, vt_r, vm1_r, vm2_r, vp_r, vb_r;
  logic                  vr_r, vs_r, vd1_r, vd2_r;
  logic [DIV_STG-1:0]    dvv_r;

  // numerator stages
  ray_t                  ray1_r, ray2_r, ray3_r, ray4_r;
  logic signed [NW-1:0]  num_nxt [NFACE];
  logic signed [NW-1:0]  num2_r  [NFACE];
  logic [DW-1:0]         dm_nxt  [NAXIS];
  logic [DW-1:0]         dm2_r [NAXIS], dm3_r [NAXIS], dm4_r [NAXIS];
  logic [NW-1:0]         n3_r   [NFACE];
  logic                  neg3_r [NFACE];
  logic                  en3_r  [NFACE];
  fdiv_t                 d4_nxt [NFACE];
  fdiv_t                 d4_r   [NFACE];

  // divider
  fdiv_t                 dv_nxt [DIV_STG][NFACE];
  fdiv_t                 dv_r   [DIV_STG][NFACE];
  ray_t                  dray_r [DIV_STG];
  logic [DW-1:0]         ddm_r  [DIV_STG][NAXIS];

  // distance and hit point
  logic [FW-1:0]         tm_nxt [NFACE];
  logic                  tn_nxt [NFACE];
  logic [FW-1:0]         tm_r [NFACE];
  logic                  tn_r [NFACE];
  logic                  ten_r [NFACE];
  ray_t                  rayt_r;
  logic [DW-1:0]         dmt_r [NAXIS];
  logic [63:0]           mlo_r  [NFACE][NAXIS];
  logic [FW-1:0]         mhi_r  [NFACE][NAXIS];
  logic                  mneg_r [NFACE][NAXIS];
  logic [FW-1:0]         ts1_r [NFACE];
  logic                  en1_r [NFACE];
  ray_t                  ray5_r;
  logic [MW-1:0]         prod_nxt [NFACE][NAXIS];
  logic [MW-1:0]         prod_r   [NFACE][NAXIS];
  logic [FW-1:0]         ts2_r [NFACE];
  logic                  en2_r [NFACE];
  ray_t                  ray6_r;
  logic [FW-1:0]         pos_r [NFACE][NAXIS];
  logic [FW-1:0]         ts3_r [NFACE];
  logic                  en4_r [NFACE];
  ray_t                  ray7_r;

  // bounds, ranking, borders
  hit_t                  hb_nxt [NFACE];
  logic                  okb_nxt [NFACE];
  hit_t                  hb_r [NFACE];
  logic                  okb_r [NFACE];
  logic [CNTW-1:0]       rank_nxt [NFACE];
  logic [CNTW-1:0]       nh_nxt, np_nxt;
  hit_t                  hr_r [NFACE];
  logic                  okr_r [NFACE];
  logic [CNTW-1:0]       rank_r [NFACE];
  logic [CNTW-1:0]       nhr_r, npr_r;
  hit_t                  slot_nxt [NFACE];
  hit_t                  slot_r [NFACE];
  logic [CNTW-1:0]       nhs_r, nps_r, fps_r;
  logic [FW-1:0]         p0, p1, bn1_nxt, bf1_nxt;
  hit_t                  slot1_r [NFACE];
  logic [CNTW-1:0]       nh1_r;
  logic [FW-1:0]         bn1_r, bf1_r;
  logic [FW-1:0]         bn2_nxt, bf2_nxt, bsw;
  loc_t                  loc2_nxt;
  hit_t                  slotf_r [NFACE];
  logic [CNTW-1:0]       nhf_r, cntf_r;
  logic [FW-1:0]         bnf_r, bff_r;
  loc_t                  locf_r;

  // result serialiser and output register
  logic                  bvld_r;
  hit_t                  bslot_r [NFACE];
  logic [CNTW-1:0]       bnh_r, bcnt_r, bidx_r;
  logic [FW-1:0]         bbn_r, bbf_r;
  loc_t                  bloc_r;
  logic                  ovld_r;
  res_t                  ores_r;
  res_t                  res_nxt;
  hit_t                  sel;
  logic                  out_free, emit, blast, bfree;

  // ---------------------------------------------------------------- configuration
  assign cfg_wr = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[AW-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NAXIS; k++) begin
        center_r[k] <= '0;
        size_r[k]   <= '0;
      end
      prec_r <= PREC_RST;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_CENTER_X:  center_r[0] <= pwdata[FW-1:0];
        REG_CENTER_Y:  center_r[1] <= pwdata[FW-1:0];
        REG_CENTER_Z:  center_r[2] <= pwdata[FW-1:0];
        REG_SIZE_X:    size_r[0]   <= pwdata[EW-1:0];
        REG_SIZE_Y:    size_r[1]   <= pwdata[EW-1:0];
        REG_SIZE_Z:    size_r[2]   <= pwdata[EW-1:0];
        REG_PRECISION: prec_r      <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_CENTER_X:  prdata = {{(XW-FW){center_r[0][FW-1]}}, center_r[0]};
      REG_CENTER_Y:  prdata = {{(XW-FW){center_r[1][FW-1]}}, center_r[1]};
      REG_CENTER_Z:  prdata = {{(XW-FW){center_r[2][FW-1]}}, center_r[2]};
      REG_SIZE_X:    prdata = {{(XW-EW){1'b0}}, size_r[0]};
      REG_SIZE_Y:    prdata = {{(XW-EW){1'b0}}, size_r[1]};
      REG_SIZE_Z:    prdata = {{(XW-EW){1'b0}}, size_r[2]};
      REG_PRECISION: prdata = {{(XW-PW){1'b0}}, prec_r};
      default:       prdata = '0;
    endcase
  end

  // Face planes are kept at twice the scale so that a half extent stays exact.
  always_comb begin
    for (int k = 0; k < NAXIS; k++) begin
      plo[k] = $signed({center_r[k][FW-1], center_r[k], 1'b0}) - $signed({3'b000, size_r[k]});
      phi[k] = $signed({center_r[k][FW-1], center_r[k], 1'b0}) + $signed({3'b000, size_r[k]});
    end
  end

  // ---------------------------------------------------------------- pipeline control
  assign adv      = !vd2_r || bfree;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      dvv_r <= '0;
      vt_r  <= 1'b0;
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vp_r  <= 1'b0;
      vb_r  <= 1'b0;
      vr_r  <= 1'b0;
      vs_r  <= 1'b0;
      vd1_r <= 1'b0;
      vd2_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      dvv_r <= {dvv_r[DIV_STG-2:0], v4_r};
      vt_r  <= dvv_r[DIV_STG-1];
      vm1_r <= vt_r;
      vm2_r <= vm1_r;
      vp_r  <= vm2_r;
      vb_r  <= vp_r;
      vr_r  <= vb_r;
      vs_r  <= vr_r;
      vd1_r <= vs_r;
      vd2_r <= vd1_r;
    end
  end

  // ---------------------------------------------------------------- numerators
  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      if ((f % 2) == 0) begin
        num_nxt[f] = $signed({phi[f/2][PLW-1], phi[f/2]})
                   - $signed({{2{ray1_r.o[f/2][FW-1]}}, ray1_r.o[f/2], 1'b0});
      end else begin
        num_nxt[f] = $signed({plo[f/2][PLW-1], plo[f/2]})
                   - $signed({{2{ray1_r.o[f/2][FW-1]}}, ray1_r.o[f/2], 1'b0});
      end
    end
    for (int k = 0; k < NAXIS; k++) begin
      dm_nxt[k] = ray1_r.d[k][DW-1] ? (~ray1_r.d[k] + 32'd1) : ray1_r.d[k];
    end
  end

  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      d4_nxt[f].ovf = n3_r[f] >= {1'b0, dm3_r[f/2], {NLW{1'b0}}};
      d4_nxt[f].rem = n3_r[f][NLW+RW-1:NLW];
      d4_nxt[f].nlo = n3_r[f][NLW-1:0];
      d4_nxt[f].quo = '0;
      d4_nxt[f].neg = neg3_r[f];
      d4_nxt[f].en  = en3_r[f];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray1_r.o[0] <= in_origin_x;
      ray1_r.o[1] <= in_origin_y;
      ray1_r.o[2] <= in_origin_z;
      ray1_r.d[0] <= in_dir_x;
      ray1_r.d[1] <= in_dir_y;
      ray1_r.d[2] <= in_dir_z;
      ray2_r      <= ray1_r;
      ray3_r      <= ray2_r;
      ray4_r      <= ray3_r;
      for (int k = 0; k < NAXIS; k++) begin
        dm2_r[k] <= dm_nxt[k];
        dm3_r[k] <= dm2_r[k];
        dm4_r[k] <= dm3_r[k];
      end
      for (int f = 0; f < NFACE; f++) begin
        num2_r[f] <= num_nxt[f];
        n3_r[f]   <= num2_r[f][NW-1] ? (~num2_r[f] + 51'd1) : num2_r[f];
        neg3_r[f] <= num2_r[f][NW-1] ^ ray2_r.d[f/2][DW-1];
        en3_r[f]  <= ray2_r.d[f/2] != '0;
        d4_r[f]   <= d4_nxt[f];
      end
    end
  end

  // ---------------------------------------------------------------- divider
  always_comb begin
    for (int j = 0; j < DIV_STG; j++) begin
      for (int f = 0; f < NFACE; f++) begin
        if (j == 0) begin
          dv_nxt[j][f] = div_step(d4_r[f], dm4_r[f/2], j);
        end else begin
          dv_nxt[j][f] = div_step(dv_r[j-1][f], ddm_r[j-1][f/2], j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_STG; j++) begin
        for (int f = 0; f < NFACE; f++) begin
          dv_r[j][f] <= dv_nxt[j][f];
        end
        if (j == 0) begin
          dray_r[j] <= ray4_r;
          for (int k = 0; k < NAXIS; k++) ddm_r[j][k] <= dm4_r[k];
        end else begin
          dray_r[j] <= dray_r[j-1];
          for (int k = 0; k < NAXIS; k++) ddm_r[j][k] <= ddm_r[j-1][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- distance
  // Distances are kept as magnitude and sign until the multipliers; a small positive
  // distance collapses to zero.
  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      if (dv_r[DIV_STG-1][f].ovf) begin
        tm_nxt[f] = dv_r[DIV_STG-1][f].neg ? T_MIN : T_MAX;
      end else begin
        tm_nxt[f] = {1'b0, dv_r[DIV_STG-1][f].quo};
      end
      if (!dv_r[DIV_STG-1][f].neg && tm_nxt[f] < {{(FW-PW){1'b0}}, prec_r}) begin
        tm_nxt[f] = '0;
      end
      tn_nxt[f] = dv_r[DIV_STG-1][f].neg && (tm_nxt[f] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rayt_r <= dray_r[DIV_STG-1];
      for (int k = 0; k < NAXIS; k++) dmt_r[k] <= ddm_r[DIV_STG-1][k];
      for (int f = 0; f < NFACE; f++) begin
        tm_r[f]  <= tm_nxt[f];
        tn_r[f]  <= tn_nxt[f];
        ten_r[f] <= dv_r[DIV_STG-1][f].en;
      end
    end
  end

  // ---------------------------------------------------------------- hit points
  always_ff @(posedge clk) begin
    if (adv) begin
      ray5_r <= rayt_r;
      for (int f = 0; f < NFACE; f++) begin
        ts1_r[f] <= tn_r[f] ? (~tm_r[f] + 48'd1) : tm_r[f];
        en1_r[f] <= ten_r[f];
        for (int k = 0; k < NAXIS; k++) begin
          mlo_r[f][k]  <= 64'(tm_r[f][31:0]) * 64'(dmt_r[k]);
          mhi_r[f][k]  <= 48'(tm_r[f][FW-1:32]) * 48'(dmt_r[k]);
          mneg_r[f][k] <= tn_r[f] ^ rayt_r.d[k][DW-1];
        end
      end
    end
  end

  // The product is floored, so a negative one with a remainder steps one further down.
  always_comb begin
    logic [MW-1:0] q;
    logic          rem;
    for (int f = 0; f < NFACE; f++) begin
      for (int k = 0; k < NAXIS; k++) begin
        q   = {2'b00, mhi_r[f][k], 2'b00} + {18'b0, mlo_r[f][k][63:30]};
        rem = |mlo_r[f][k][29:0];
        if (mneg_r[f][k]) begin
          prod_nxt[f][k] = rem ? ~q : (~q + 52'd1);
        end else begin
          prod_nxt[f][k] = q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray6_r <= ray5_r;
      ray7_r <= ray6_r;
      for (int f = 0; f < NFACE; f++) begin
        ts2_r[f] <= ts1_r[f];
        en2_r[f] <= en1_r[f];
        ts3_r[f] <= ts2_r[f];
        en4_r[f] <= en2_r[f];
        for (int k = 0; k < NAXIS; k++) begin
          prod_r[f][k] <= prod_nxt[f][k];
          pos_r[f][k]  <= sat48({{5{ray6_r.o[k][FW-1]}}, ray6_r.o[k]}
                                + {prod_r[f][k][MW-1], prod_r[f][k]});
        end
      end
    end
  end

  // ---------------------------------------------------------------- bounds test
  always_comb begin
    logic signed [PLW-1:0] tp;
    for (int f = 0; f < NFACE; f++) begin
      okb_nxt[f]   = en4_r[f];
      hb_nxt[f].t  = ts3_r[f];
      for (int k = 0; k < NAXIS; k++) begin
        hb_nxt[f].p[k] = pos_r[f][k];
        tp = $signed({pos_r[f][k][FW-1], pos_r[f][k], 1'b0});
        if (k != f / 2) begin
          if (tp < plo[k] || tp > phi[k]) okb_nxt[f] = 1'b0;
        end
      end
      hb_nxt[f].ent = ((f % 2) == 0) ? ray7_r.d[f/2][DW-1] : !ray7_r.d[f/2][DW-1];
    end
  end

  // Rank by distance; equal distances keep face order.
  always_comb begin
    nh_nxt = '0;
    np_nxt = '0;
    for (int i = 0; i < NFACE; i++) begin
      rank_nxt[i] = '0;
      for (int j = 0; j < NFACE; j++) begin
        if (okb_r[j] && j != i) begin
          if ($signed(hb_r[j].t) < $signed(hb_r[i].t)
              || (hb_r[j].t == hb_r[i].t && j < i)) begin
            rank_nxt[i] = rank_nxt[i] + 3'd1;
          end
        end
      end
      if (okb_r[i]) begin
        nh_nxt = nh_nxt + 3'd1;
        if ($signed(hb_r[i].t) > 0) np_nxt = np_nxt + 3'd1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NFACE; k++) begin
      slot_nxt[k] = '0;
      for (int i = 0; i < NFACE; i++) begin
        if (okr_r[i] && rank_r[i] == 3'(k)) slot_nxt[k] = hr_r[i];
      end
    end
  end

  // Positive distances sit at the far end of the sorted list.
  always_comb begin
    p0 = '0;
    p1 = '0;
    for (int k = 0; k < NFACE; k++) begin
      if (3'(k) == fps_r)         p0 = slot_r[k].t;
      if (3'(k) == fps_r + 3'd1)  p1 = slot_r[k].t;
    end
    case (nps_r)
      3'd1: begin
        bn1_nxt = p0;
        bf1_nxt = NONE_DIST;
      end
      3'd2: begin
        bn1_nxt = p0;
        bf1_nxt = p1;
      end
      default: begin
        bn1_nxt = NONE_DIST;
        bf1_nxt = NONE_DIST;
      end
    endcase
  end

  always_comb begin
    bn2_nxt = bn1_r;
    bf2_nxt = bf1_r;
    if ($signed(bn2_nxt) < $signed({{(FW-PW){1'b0}}, prec_r})) bn2_nxt = NONE_DIST;
    if ($signed(bf2_nxt) < $signed({{(FW-PW){1'b0}}, prec_r})) bf2_nxt = NONE_DIST;
    if (bn2_nxt[FW-1]) begin
      bsw     = bn2_nxt;
      bn2_nxt = bf2_nxt;
      bf2_nxt = bsw;
    end else begin
      bsw = '0;
    end
    if ($signed(bn2_nxt) > 0 && $signed(bf2_nxt) > 0) begin
      loc2_nxt = LOC_FRONT;
    end else if ($signed(bn2_nxt) > 0 && bf2_nxt[FW-1]) begin
      loc2_nxt = LOC_INSIDE;
    end else begin
      loc2_nxt = LOC_BEHIND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int f = 0; f < NFACE; f++) begin
        hb_r[f]    <= hb_nxt[f];
        okb_r[f]   <= okb_nxt[f];
        hr_r[f]    <= hb_r[f];
        okr_r[f]   <= okb_r[f];
        rank_r[f]  <= rank_nxt[f];
        slot_r[f]  <= slot_nxt[f];
        slot1_r[f] <= slot_r[f];
        slotf_r[f] <= slot1_r[f];
      end
      nhr_r  <= nh_nxt;
      npr_r  <= np_nxt;
      nhs_r  <= nhr_r;
      nps_r  <= npr_r;
      fps_r  <= nhr_r - npr_r;
      nh1_r  <= nhs_r;
      bn1_r  <= bn1_nxt;
      bf1_r  <= bf1_nxt;
      nhf_r  <= nh1_r;
      cntf_r <= (nh1_r == '0) ? 3'd1 : nh1_r;
      bnf_r  <= bn2_nxt;
      bff_r  <= bf2_nxt;
      locf_r <= loc2_nxt;
    end
  end

  // ---------------------------------------------------------------- result serialiser
  assign out_free = !ovld_r || !out_stall;
  assign emit     = bvld_r && out_free;
  assign blast    = bidx_r == bcnt_r - 3'd1;
  assign bfree    = !bvld_r || (emit && blast);

  always_comb begin
    sel = '0;
    for (int k = 0; k < NFACE; k++) begin
      if (3'(k) == bidx_r) sel = bslot_r[k];
    end
    res_nxt.hit_valid = bnh_r != '0;
    res_nxt.hit       = res_nxt.hit_valid ? sel : '0;
    res_nxt.bn        = bbn_r;
    res_nxt.bf        = bbf_r;
    res_nxt.loc       = bloc_r;
    res_nxt.last      = blast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r <= 1'b0;
      bidx_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (vd2_r && bfree) begin
        bvld_r <= 1'b1;
        bidx_r <= '0;
      end else if (emit) begin
        if (blast) begin
          bvld_r <= 1'b0;
        end else begin
          bidx_r <= bidx_r + 3'd1;
        end
      end
      if (out_free) begin
        ovld_r <= bvld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vd2_r && bfree) begin
      for (int k = 0; k < NFACE; k++) bslot_r[k] <= slotf_r[k];
      bnh_r  <= nhf_r;
      bcnt_r <= cntf_r;
      bbn_r  <= bnf_r;
      bbf_r  <= bff_r;
      bloc_r <= locf_r;
    end
    if (emit) begin
      ores_r <= res_nxt;
    end
  end

  assign out_valid        = ovld_r;
  assign out_hit_valid    = ores_r.hit_valid;
  assign out_hit_distance = ores_r.hit.t;
  assign out_hit_x        = ores_r.hit.p[0];
  assign out_hit_y        = ores_r.hit.p[1];
  assign out_hit_z        = ores_r.hit.p[2];
  assign out_entering     = ores_r.hit.ent;
  assign out_border_near  = ores_r.bn;
  assign out_border_far   = ores_r.bf;
  assign out_location     = ores_r.loc;
  assign out_last         = ores_r.last;

endmodule

>>> rtl/rbi_checker.sv
module rbi_checker import rbi_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input logic          out_hit_valid,
  input logic [FW-1:0] out_hit_distance,
  input logic [FW-1:0] out_border_near,
  input logic [FW-1:0] out_border_far,
  input logic [1:0]    out_location,
  input logic          out_last
);

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_distance) && $stable(out_last)
                               && $stable(out_hit_valid))
    else $error("result beat changed while stalled");

  // A missed box gives exactly one beat with a zero distance.
  a_miss_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_valid |-> out_last && out_hit_distance == '0)
    else $error("miss beat is not a single zeroed beat");

  a_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_location == LOC_FRONT |->
      !out_border_near[FW-1] && out_border_near != '0
      && !out_border_far[FW-1] && out_border_far != '0)
    else $error("box in front without two positive borders");

  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_location == LOC_INSIDE |-> out_border_far == NONE_DIST)
    else $error("origin inside with a far border");

  a_behind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_location == LOC_BEHIND |->
      out_border_near == NONE_DIST && out_border_far == NONE_DIST)
    else $error("box behind with a border set");

endmodule

bind ray_box_intersection rbi_checker u_rbi_checker (.*);
